// ----- hdl/boundary_tag_heap_allocator_defines.svh -----
// Assertion macros used by the allocator controller (bth_ctrl).
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BTH_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define BTH_ASSERT(lbl, prop, msg)
`define BTH_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/bth_pkg.sv -----
package bth_pkg;
	localparam int HEAP_BYTES = 127;
	localparam int AW = $clog2(HEAP_BYTES);
	localparam logic [AW-1:0] MAX_REQ = AW'(HEAP_BYTES - 2);
	localparam logic [AW:0] HEAP_END = (AW+1)'(HEAP_BYTES);

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
	localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [7:0]    wdata;
	} mem_cmd_t;

	function automatic logic [7:0] reset_byte(input logic [AW-1:0] a);
		return (a == '0 || a == AW'(HEAP_BYTES - 1)) ? 8'(HEAP_BYTES << 1) : 8'd0;
	endfunction
endpackage

// ----- hdl/bth_dp.sv -----
module bth_dp import bth_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_cmd_t   cmd,
	output logic [7:0] rdata
);
	logic [7:0] mem [HEAP_BYTES];
	logic [HEAP_BYTES-1:0] valid_q;
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= valid_q[cmd.rd_addr] ? mem[cmd.rd_addr] : reset_byte(cmd.rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[cmd.wr_addr] <= 1'b1;
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/bth_ctrl.sv -----
`include "boundary_tag_heap_allocator_defines.svh"
module bth_ctrl import bth_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_opcode,
	input  logic [AW-1:0] in_req,
	input  logic [AW-1:0] in_addr,
	input  logic [7:0]    in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    out_status,
	output logic [AW-1:0] out_paddr,
	output logic [7:0]    out_rbyte,
	output mem_cmd_t      cmd,
	input  logic [7:0]    rdata
);
	typedef enum logic [4:0] {
		IDLE, BYTE_OP, RD_WAIT, A_RD, A_CHK, A_SEL, A_S0, A_S1,
		A_W0, A_W1, A_W2, A_W3, F_RD, F_CHK, F_CLR, F_WH, F_WF,
		P_RD, P_CHK, P_W0, P_W1, P_W2, P_W3, N_RD, N_CHK,
		N_W0, N_W1, N_W2, N_W3, DONE
	} state_t;

	state_t state_q;
	logic policy_q, pick_v_q, out_valid_q;
	logic [1:0] op_q;
	logic [AW-1:0] need_q, addr_q, pos_q, h_q, sz_q, best_q, f_q, start_q, total_q, end_q;
	logic [7:0] data_q, rb_q, orb_q;
	logic [2:0] st_q, ost_q;
	logic [AW-1:0] pa_q, opa_q;

	logic [AW-1:0] tsz, left;
	logic [AW:0] sum;
	logic tused;

	assign tsz = rdata[7:1];
	assign tused = rdata[0];
	assign sum = {1'b0, pos_q} + {1'b0, tsz};
	assign left = tsz - need_q;
	assign in_ready = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign out_status = ost_q;
	assign out_paddr = opa_q;
	assign out_rbyte = orb_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			BYTE_OP: begin
				cmd.rd_en = (op_q == OP_READ);
				cmd.rd_addr = addr_q;
				cmd.wr_en = (op_q == OP_WRITE);
				cmd.wr_addr = addr_q;
				cmd.wdata = data_q;
			end
			A_RD, F_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = pos_q;
			end
			A_S0: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q;
				cmd.wdata = {sz_q, 1'b1};
				cmd.rd_en = 1'b1;
				cmd.rd_addr = h_q + sz_q - AW'(1);
			end
			A_S1: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q + sz_q - AW'(1);
				cmd.wdata = rdata | 8'd1;
			end
			A_W0: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q;
				cmd.wdata = {need_q, 1'b1};
			end
			A_W1: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q + need_q - AW'(1);
				cmd.wdata = {need_q, 1'b1};
			end
			A_W2: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q + need_q;
				cmd.wdata = {best_q, 1'b0};
			end
			A_W3: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q + sz_q - AW'(1);
				cmd.wdata = {best_q, 1'b0};
			end
			F_CLR: begin
				cmd.wr_en = (pos_q < f_q);
				cmd.wr_addr = pos_q;
			end
			F_WH: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q;
				cmd.wdata = {sz_q, 1'b0};
			end
			F_WF: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = f_q;
				cmd.wdata = {sz_q, 1'b0};
			end
			P_RD: begin
				cmd.rd_en = (h_q != '0);
				cmd.rd_addr = h_q - AW'(1);
			end
			P_W0: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q - AW'(1);
			end
			P_W1: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = h_q;
			end
			P_W2, N_W2: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = start_q;
				cmd.wdata = {total_q, 1'b0};
			end
			P_W3: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = f_q;
				cmd.wdata = {total_q, 1'b0};
			end
			N_RD: begin
				cmd.rd_en = (f_q < AW'(HEAP_BYTES - 1));
				cmd.rd_addr = f_q + AW'(1);
			end
			N_W0: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = f_q;
			end
			N_W1: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = f_q + AW'(1);
			end
			N_W3: begin
				cmd.wr_en = 1'b1;
				cmd.wr_addr = end_q;
				cmd.wdata = {total_q, 1'b0};
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			policy_q <= 1'b0;
			out_valid_q <= 1'b0;
			pick_v_q <= 1'b0;
			op_q <= OP_ALLOC;
			need_q <= '0;
			addr_q <= '0;
			pos_q <= '0;
			h_q <= '0;
			sz_q <= '0;
			best_q <= '0;
			f_q <= '0;
			start_q <= '0;
			total_q <= '0;
			end_q <= '0;
			data_q <= '0;
			rb_q <= '0;
			st_q <= ST_OK;
			pa_q <= '0;
			ost_q <= ST_OK;
			opa_q <= '0;
			orb_q <= '0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						op_q <= in_opcode;
						addr_q <= in_addr;
						data_q <= in_data;
						need_q <= in_req + AW'(2);
						st_q <= ST_OK;
						pa_q <= '0;
						rb_q <= '0;
						pos_q <= '0;
						pick_v_q <= 1'b0;
						h_q <= in_addr - AW'(1);
						if (in_opcode == OP_ALLOC) begin
							if (in_req == '0 || in_req > MAX_REQ) begin
								st_q <= ST_BAD_SIZE;
								state_q <= DONE;
							end else begin
								state_q <= A_RD;
							end
						end else if (in_addr >= AW'(HEAP_BYTES) ||
								(in_opcode == OP_FREE && in_addr == '0)) begin
							st_q <= ST_BAD_ADDR;
							state_q <= DONE;
						end else if (in_opcode == OP_FREE) begin
							state_q <= F_RD;
						end else begin
							state_q <= BYTE_OP;
						end
					end
				end
				BYTE_OP: state_q <= (op_q == OP_READ) ? RD_WAIT : DONE;
				RD_WAIT: begin
					rb_q <= rdata;
					state_q <= DONE;
				end
				A_RD: state_q <= A_CHK;
				A_CHK: begin
					if (tsz == '0 || sum > HEAP_END) begin
						state_q <= A_SEL;
					end else begin
						if (!tused && tsz >= need_q && (!pick_v_q || left < best_q)) begin
							pick_v_q <= 1'b1;
							h_q <= pos_q;
							sz_q <= tsz;
							best_q <= left;
						end
						pos_q <= sum[AW-1:0];
						if ((!tused && tsz >= need_q && !policy_q) || sum >= HEAP_END) begin
							state_q <= A_SEL;
						end else begin
							state_q <= A_RD;
						end
					end
				end
				A_SEL: begin
					if (!pick_v_q) begin
						st_q <= ST_NO_SPACE;
						state_q <= DONE;
					end else begin
						pa_q <= h_q + AW'(1);
						state_q <= (best_q >= AW'(3)) ? A_W0 : A_S0;
					end
				end
				A_S0: state_q <= A_S1;
				A_S1: state_q <= DONE;
				A_W0: state_q <= A_W1;
				A_W1: state_q <= A_W2;
				A_W2: state_q <= A_W3;
				A_W3: state_q <= DONE;
				F_RD: state_q <= F_CHK;
				F_CHK: begin
					if (pos_q == h_q) begin
						if (tsz != '0 && sum <= HEAP_END) begin
							if (!tused) begin
								st_q <= ST_NOT_ALLOC;
								state_q <= DONE;
							end else begin
								sz_q <= tsz;
								f_q <= h_q + tsz - AW'(1);
								pos_q <= h_q + AW'(1);
								state_q <= F_CLR;
							end
						end else begin
							st_q <= ST_BAD_ADDR;
							state_q <= DONE;
						end
					end else if (tsz == '0 || sum >= HEAP_END) begin
						st_q <= ST_BAD_ADDR;
						state_q <= DONE;
					end else begin
						pos_q <= sum[AW-1:0];
						state_q <= F_RD;
					end
				end
				F_CLR: begin
					if (pos_q < f_q) begin
						pos_q <= pos_q + AW'(1);
					end else begin
						state_q <= F_WH;
					end
				end
				F_WH: state_q <= F_WF;
				F_WF: begin
					start_q <= h_q;
					total_q <= sz_q;
					state_q <= P_RD;
				end
				P_RD: state_q <= (h_q != '0) ? P_CHK : N_RD;
				P_CHK: begin
					if (!tused && tsz != '0 && tsz <= h_q) begin
						start_q <= h_q - tsz;
						total_q <= tsz + sz_q;
						state_q <= P_W0;
					end else begin
						state_q <= N_RD;
					end
				end
				P_W0: state_q <= P_W1;
				P_W1: state_q <= P_W2;
				P_W2: state_q <= P_W3;
				P_W3: state_q <= N_RD;
				N_RD: state_q <= (f_q < AW'(HEAP_BYTES - 1)) ? N_CHK : DONE;
				N_CHK: begin
					if (!tused && tsz != '0 &&
							({1'b0, f_q} + {1'b0, tsz}) < HEAP_END) begin
						total_q <= total_q + tsz;
						end_q <= f_q + tsz;
						state_q <= N_W0;
					end else begin
						state_q <= DONE;
					end
				end
				N_W0: state_q <= N_W1;
				N_W1: state_q <= N_W2;
				N_W2: state_q <= N_W3;
				N_W3: state_q <= DONE;
				DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ost_q <= st_q;
						opa_q <= pa_q;
						orb_q <= rb_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`BTH_NEVER(a_rw_clash, cmd.rd_en && cmd.wr_en && cmd.rd_addr == cmd.wr_addr, "read and write hit the same byte")
	`BTH_ASSERT(a_accept_busy, in_valid && in_ready |=> state_q != IDLE, "accepted word did not start work")
	`BTH_ASSERT(a_split_slack, state_q == A_W0 |-> best_q >= AW'(3), "split with too little slack")
	`BTH_ASSERT(a_status_range, out_valid_q |-> ost_q <= ST_NOT_ALLOC, "status code out of range")
endmodule

// ----- hdl/boundary_tag_heap_allocator.sv -----
// Channel  | Handshake                     | Payload
// s_axis   | s_axis_tvalid / s_axis_tready | opcode, request_size, byte_address, write_byte
// m_axis   | m_axis_tvalid / m_axis_tready | status, payload_address, read_byte
// cfg      | cfg_we                        | fit_policy
// One word is processed at a time; the heap memory has one write and one registered read port.
// Write runs BYTE_OP then DONE, read adds RD_WAIT; a bad request goes straight to DONE.
// Allocate walks tags (A_RD, A_CHK), picks in A_SEL, writes tags in A_S0/A_S1 or A_W0-A_W3.
// Free walks blocks (F_RD, F_CHK), clears payload in F_CLR, then merges free neighbours.
// Reset is immediate; the next word is taken while a result waits on m_axis.
module boundary_tag_heap_allocator import bth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], request_size[8:2], byte_address[15:9], write_byte[23:16]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], payload_address[9:3], read_byte[17:10], zero fill above
	output logic [23:0] m_axis_tdata
);
	mem_cmd_t cmd;
	logic [7:0] rdata;
	logic [2:0] status;
	logic [AW-1:0] payload_address;
	logic [7:0] read_byte;

	bth_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_opcode(s_axis_tdata[1:0]),
		.in_req(s_axis_tdata[8:2]),
		.in_addr(s_axis_tdata[15:9]),
		.in_data(s_axis_tdata[23:16]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_status(status),
		.out_paddr(payload_address),
		.out_rbyte(read_byte),
		.cmd(cmd),
		.rdata(rdata)
	);

	bth_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rdata(rdata)
	);

	assign m_axis_tdata = {6'd0, read_byte, payload_address, status};
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import bth_pkg::*;

	typedef struct packed {
		logic [7:0] wbyte;
		logic [6:0] addr;
		logic [6:0] size;
		logic [1:0] op;
	} heap_cmd_t;

	typedef struct packed {
		logic [7:0] rbyte;
		logic [6:0] paddr;
		logic [2:0] status;
	} heap_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;

	boundary_tag_heap_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	logic [7:0] heap_model [HEAP_BYTES];
	logic model_best_fit;
	heap_cmd_t cmd_queue[$];
	heap_rsp_t rsp_expected[$];
	int live_blocks[$];
	int mismatches;
	int cycle_count;
	int hold_cycles;
	bit idle_on;

	localparam int CYCLE_LIMIT = 3000000;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int tsize(int i);
		return heap_model[i] >> 1;
	endfunction

	function automatic bit tused(int i);
		return heap_model[i][0];
	endfunction

	function automatic int heap_alloc(int want);
		int need, pos, pick, best, sz, left, h;
		logic [7:0] ut, ft;
		need = want + 2;
		pos = 0;
		pick = -1;
		best = 0;
		while (pos < HEAP_BYTES) begin
			sz = tsize(pos);
			if (sz == 0 || pos + sz > HEAP_BYTES) break;
			if (!tused(pos) && sz >= need) begin
				left = sz - need;
				if (pick < 0 || left < best) begin
					pick = pos;
					best = left;
				end
				if (!model_best_fit) break;
			end
			pos += sz;
		end
		if (pick >= 0) begin
			h = pick;
			sz = tsize(h);
			if (best >= 3) begin
				ut = 8'((need << 1) | 1);
				ft = 8'(best << 1);
				heap_model[h] = ut;
				heap_model[h + need - 1] = ut;
				heap_model[h + need] = ft;
				heap_model[h + sz - 1] = ft;
			end else begin
				heap_model[h][0] = 1'b1;
				heap_model[h + sz - 1][0] = 1'b1;
			end
		end
		return pick;
	endfunction

	function automatic logic [2:0] heap_free(int addr);
		int h, sz, f, start, total, pos, s, psz, n, nsz;
		bit found;
		found = 0;
		if (addr == 0 || addr >= HEAP_BYTES) return ST_BAD_ADDR;
		h = addr - 1;
		pos = 0;
		while (pos < HEAP_BYTES) begin
			s = tsize(pos);
			if (pos == h) begin
				found = (s != 0 && pos + s <= HEAP_BYTES);
				break;
			end
			if (s == 0 || pos + s > HEAP_BYTES) break;
			pos += s;
		end
		if (!found) return ST_BAD_ADDR;
		if (!tused(h)) return ST_NOT_ALLOC;
		sz = tsize(h);
		f = h + sz - 1;
		for (int i = h + 1; i < f; i++) heap_model[i] = 8'd0;
		heap_model[h] = 8'(sz << 1);
		heap_model[f] = 8'(sz << 1);
		start = h;
		total = sz;
		if (h > 0 && !tused(h - 1)) begin
			psz = tsize(h - 1);
			if (psz != 0 && psz <= h) begin
				start = h - psz;
				total = psz + sz;
				heap_model[h - 1] = 8'd0;
				heap_model[h] = 8'd0;
				heap_model[start] = 8'(total << 1);
				heap_model[f] = 8'(total << 1);
			end
		end
		if (f + 1 < HEAP_BYTES && !tused(f + 1)) begin
			n = f + 1;
			nsz = tsize(n);
			if (nsz != 0 && n + nsz <= HEAP_BYTES) begin
				total += nsz;
				heap_model[f] = 8'd0;
				heap_model[n] = 8'd0;
				heap_model[start] = 8'(total << 1);
				heap_model[n + nsz - 1] = 8'(total << 1);
			end
		end
		return ST_OK;
	endfunction

	function automatic heap_rsp_t predict_heap(heap_cmd_t c);
		heap_rsp_t r;
		int h;
		r = '0;
		r.status = ST_OK;
		if (c.op == OP_ALLOC) begin
			if (c.size == 0 || c.size > HEAP_BYTES - 2) begin
				r.status = ST_BAD_SIZE;
			end else begin
				h = heap_alloc(c.size);
				if (h < 0) r.status = ST_NO_SPACE;
				else r.paddr = 7'(h + 1);
			end
		end else if (c.op == OP_FREE) begin
			r.status = heap_free(c.addr);
		end else if (c.addr >= HEAP_BYTES) begin
			r.status = ST_BAD_ADDR;
		end else if (c.op == OP_WRITE) begin
			heap_model[c.addr] = c.wbyte;
		end else begin
			r.rbyte = heap_model[c.addr];
		end
		return r;
	endfunction

	function automatic heap_cmd_t mk(logic [1:0] op, int size, int addr, int wb);
		heap_cmd_t c;
		c.op = op;
		c.size = 7'(size);
		c.addr = 7'(addr);
		c.wbyte = 8'(wb);
		return c;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		heap_cmd_t c;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				void'(cmd_queue.pop_front());
				rsp_expected.push_back(predict_heap(heap_cmd_t'(s_axis_tdata[23:0])));
			end
			if ((!s_axis_tvalid || s_axis_tready) && cmd_queue.size() > 0) begin
				c = cmd_queue[0];
				if (idle_on && $urandom_range(99) < 29) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= c;
				end
			end else if (s_axis_tvalid && s_axis_tready) begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		heap_rsp_t got, exp;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = heap_rsp_t'(m_axis_tdata[17:0]);
				if (rsp_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected word %h", got);
				end else begin
					exp = rsp_expected.pop_front();
					if (exp.status == ST_OK && exp.paddr != 0) live_blocks.push_back(exp.paddr);
					if (got !== exp || m_axis_tdata[23:18] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected st=%0d pa=%0d rb=%0d, got st=%0d pa=%0d rb=%0d",
								exp.status, exp.paddr, exp.rbyte,
								got.status, got.paddr, got.rbyte);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(idle_on && $urandom_range(99) < 29);
			end
		end
	end

	task automatic drain();
		wait (cmd_queue.size() == 0 && !s_axis_tvalid && rsp_expected.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic add_random(int n);
		int r, a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 35) begin
				cmd_queue.push_back(mk(OP_ALLOC, ($urandom_range(9) == 0) ?
					$urandom_range(127) : $urandom_range(1, 20), 0, 0));
			end else if (r < 65) begin
				if (live_blocks.size() > 0 && $urandom_range(4) != 0) begin
					a = $urandom_range(live_blocks.size() - 1);
					cmd_queue.push_back(mk(OP_FREE, $urandom, live_blocks[a], 0));
					live_blocks.delete(a);
				end else begin
					cmd_queue.push_back(mk(OP_FREE, $urandom, $urandom_range(127), 0));
				end
			end else if (r < 70) begin
				cmd_queue.push_back(mk(OP_WRITE, $urandom, $urandom_range(127), $urandom));
			end else begin
				cmd_queue.push_back(mk(OP_READ, $urandom, $urandom_range(127), $urandom));
			end
		end
	endtask

	initial begin
		mismatches = 0;
		cycle_count = 0;
		hold_cycles = 0;
		idle_on = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		model_best_fit = 1'b0;
		for (int i = 0; i < HEAP_BYTES; i++) heap_model[i] = reset_byte(7'(i));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cmd_queue.push_back(mk(OP_ALLOC, 0, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 126, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 127, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 125, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 1, 0, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 1, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 1, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 0, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 127, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 5, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 10, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 4, 0, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 20, 0, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 1, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 19, 0));
		cmd_queue.push_back(mk(OP_WRITE, 0, 126, 255));
		cmd_queue.push_back(mk(OP_READ, 0, 126, 0));
		cmd_queue.push_back(mk(OP_WRITE, 0, 127, 0));
		cmd_queue.push_back(mk(OP_READ, 0, 127, 255));
		cmd_queue.push_back(mk(OP_WRITE, 0, 40, 0));
		cmd_queue.push_back(mk(OP_ALLOC, 50, 0, 0));
		cmd_queue.push_back(mk(OP_READ, 0, 0, 0));
		cmd_queue.push_back(mk(OP_WRITE, 0, 0, 8'haa));
		cmd_queue.push_back(mk(OP_ALLOC, 3, 0, 0));
		cmd_queue.push_back(mk(OP_FREE, 0, 13, 0));
		drain();

		cfg_we <= 1'b1;
		cfg_wdata <= 1'b1;
		@(posedge clk);
		model_best_fit = 1'b1;
		cfg_we <= 1'b0;
		idle_on = 1'b1;
		add_random(350);
		drain();

		hold_cycles = 400;
		add_random(300);
		drain();

		cfg_we <= 1'b1;
		cfg_wdata <= 1'b0;
		@(posedge clk);
		model_best_fit = 1'b0;
		cfg_we <= 1'b0;
		add_random(300);
		drain();

		cfg_we <= 1'b1;
		cfg_wdata <= 1'b1;
		@(posedge clk);
		model_best_fit = 1'b1;
		cfg_we <= 1'b0;
		add_random(330);
		drain();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- boundary_tag_heap_allocator.f -----
+incdir+hdl
hdl/bth_pkg.sv
hdl/bth_dp.sv
hdl/bth_ctrl.sv
hdl/boundary_tag_heap_allocator.sv
tb/sv/testbench.sv
